>>> src/wmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Workout metrics tracker package
// Shared widths, constants and structures for the tracker core and its
// session state unit.
// ----------------------------------------------------------------------------
package wmt_pkg;

   // Raw step and distance counters wrap at this many bits (16 to 32).
   localparam int CNT_W = 32;
   localparam logic [31:0] CNT_MASK = 32'hFFFF_FFFF >> (32 - CNT_W);

   localparam int SEC_W = 23;                      // clock_ms / 1000 fits here
   localparam logic [16:0] ELAPSED_MAX = 17'd86399;
   localparam logic [15:0] CAD_MAX     = 16'hFFFF;
   localparam logic [9:0]  SPEED_MAX   = 10'd1023;
   localparam logic [15:0] KM_MAX      = 16'hFFFF;
   localparam logic [32:0] CM_PER_KM   = 33'd100000;
   localparam logic [5:0]  SEC_PER_MIN = 6'd60;
   // 2^32 mod 60, the offset of a wrapped elapsed difference modulo 60.
   localparam logic [6:0]  WRAP_MOD60  = 7'd16;

   // Speed is min(dd * 600 / 100000, 1023); at or above this distance it
   // always saturates, so the per-minute distance is kept clamped to it.
   localparam logic [17:0] SPD_DD_CLAMP = 18'd170667;

   // Reciprocals for division by constants: floor(n / d) = (n * M) >> S.
   localparam logic [29:0] DIV125_M36 = 30'd549755814;    // (clk >> 3) / 125
   localparam logic [21:0] DIV15_M25  = 22'd2236963;      // (sec >> 2) / 15
   localparam logic [30:0] DIV25_M35  = 31'd1374389535;   // (cm >> 2) / 25
   localparam logic [17:0] DIV125_M24 = 18'd134218;       // (3dd >> 2) / 125

   // Intensity stage thresholds on cadence.
   localparam logic [15:0] STAGE1_MIN = 16'd80;
   localparam logic [15:0] STAGE2_MIN = 16'd100;
   localparam logic [15:0] STAGE3_MIN = 16'd120;
   localparam logic [15:0] STAGE4_MIN = 16'd140;
   localparam logic [15:0] STAGE5_MIN = 16'd160;

   // Opcodes and register indexes.
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_TOGGLE = 1'b1;

   localparam logic [1:0] REG_MIN_CADENCE = 2'd0;
   localparam logic [1:0] REG_PACE_HOLD   = 2'd1;
   localparam logic [1:0] REG_SHOW_MIN    = 2'd2;
   localparam logic [1:0] REG_SHOW_MAX    = 2'd3;

   localparam logic [7:0]  RST_MIN_CADENCE = 8'd80;
   localparam logic [7:0]  RST_PACE_HOLD   = 8'd60;
   localparam logic [11:0] RST_SHOW_MIN    = 12'd240;
   localparam logic [11:0] RST_SHOW_MAX    = 12'd1200;

   typedef struct packed {
      logic [7:0]  min_cadence;
      logic [7:0]  pace_hold;
      logic [11:0] show_min;
      logic [11:0] show_max;
   } cfg_type;

   // An item after the time split, as the session unit sees it.
   typedef struct packed {
      logic             opcode;
      logic [SEC_W-1:0] sec;
      logic [5:0]       secmod;
      logic [4:0]       hour;
      logic [5:0]       minute;
      logic [31:0]      steps;
      logic [31:0]      distance;
   } item_type;

   // Session unit result, before the output divisions.
   typedef struct packed {
      logic [16:0] elapsed;
      logic [31:0] steps;
      logic [31:0] dist_cm;
      logic [17:0] speed_dd;
      logic [15:0] cadence;
      logic [16:0] pace;
      logic        pace_visible;
      logic        full_refresh;
      logic        vibrate;
      logic        active;
   } sess_res_type;

   function automatic logic [31:0] cnt_diff(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = (a & CNT_MASK) - (b & CNT_MASK);
      return d & CNT_MASK;
   endfunction

endpackage
`default_nettype wire

>>> src/wmt_session.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Workout metrics tracker session unit
// Holds the session state and works out one item's state update and result
// in a single pass; the state changes when fire is high.
// ----------------------------------------------------------------------------
module wmt_session (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire wmt_pkg::item_type     item,
   input  wire wmt_pkg::cfg_type      cfg,
   output wmt_pkg::sess_res_type      res
);

   logic                      running_ff, running_in;
   logic                      armed_ff, armed_in;
   logic [wmt_pkg::SEC_W-1:0] start_sec_ff, start_sec_in;
   logic [5:0]                start_mod_ff, start_mod_in;
   logic [31:0]               base_steps_ff, base_steps_in;
   logic [31:0]               base_dist_ff, base_dist_in;
   logic [31:0]               min_steps_ff, min_steps_in;
   logic [31:0]               min_dist_ff, min_dist_in;
   logic [16:0]               last_mark_ff, last_mark_in;
   logic [15:0]               km_done_ff, km_done_in;
   logic [32:0]               km_next_ff, km_next_in;
   logic [7:0]                hold_ff, hold_in;
   logic [17:0]               speed_dd_ff, speed_dd_in;
   logic [15:0]               cadence_ff, cadence_in;
   logic [16:0]               pace_ff, pace_in;

   logic                      raw_ge;
   logic [wmt_pkg::SEC_W-1:0] raw_diff;
   logic [16:0]               elapsed;
   logic [6:0]                wrap_sum;
   logic [5:0]                wrap_mod;
   logic                      minute_hit;
   logic [31:0]               sess_steps;
   logic [31:0]               sess_cm;
   logic [31:0]               min_delta;
   logic [31:0]               min_dd;
   logic                      km_reached;
   logic [16:0]               pace_calc;
   logic                      midnight;

   assign raw_ge   = item.sec >= start_sec_ff;
   assign raw_diff = item.sec - start_sec_ff;
   // A clock that went backwards gives a huge wrapped difference.
   assign elapsed  = !raw_ge ? wmt_pkg::ELAPSED_MAX :
                     (raw_diff > wmt_pkg::SEC_W'(wmt_pkg::ELAPSED_MAX)) ?
                     wmt_pkg::ELAPSED_MAX : raw_diff[16:0];

   // The whole-minute test works on the unsaturated 32-bit difference; when
   // it wrapped, the residues differ by 2^32 mod 60.
   assign wrap_sum   = {1'b0, item.secmod} + wmt_pkg::WRAP_MOD60;
   assign wrap_mod   = (wrap_sum >= {1'b0, wmt_pkg::SEC_PER_MIN}) ?
                       6'(wrap_sum - {1'b0, wmt_pkg::SEC_PER_MIN}) : wrap_sum[5:0];
   assign minute_hit = raw_ge ? (item.secmod == start_mod_ff) : (wrap_mod == start_mod_ff);

   assign sess_steps = wmt_pkg::cnt_diff(item.steps, base_steps_ff);
   assign sess_cm    = wmt_pkg::cnt_diff(item.distance, base_dist_ff);
   assign min_delta  = wmt_pkg::cnt_diff(item.steps, min_steps_ff);
   assign min_dd     = wmt_pkg::cnt_diff(item.distance, min_dist_ff);

   // metres / 1000 > km_done is the same as centimetres >= next kilometre mark.
   assign km_reached = {1'b0, sess_cm} >= km_next_ff;
   assign pace_calc  = (elapsed >= last_mark_ff) ? (elapsed - last_mark_ff) : 17'd0;
   assign midnight   = (item.hour == 5'd0) && (item.minute == 6'd0);

   always_comb begin
      running_in    = running_ff;
      armed_in      = armed_ff;
      start_sec_in  = start_sec_ff;
      start_mod_in  = start_mod_ff;
      base_steps_in = base_steps_ff;
      base_dist_in  = base_dist_ff;
      min_steps_in  = min_steps_ff;
      min_dist_in   = min_dist_ff;
      last_mark_in  = last_mark_ff;
      km_done_in    = km_done_ff;
      km_next_in    = km_next_ff;
      hold_in       = hold_ff;
      speed_dd_in   = speed_dd_ff;
      cadence_in    = cadence_ff;
      pace_in       = pace_ff;
      res           = '0;

      priority if (item.opcode == wmt_pkg::OP_TOGGLE) begin
         armed_in = 1'b0;
         if (!running_ff) begin
            running_in  = 1'b1;
            speed_dd_in = '0;
            cadence_in  = '0;
            pace_in     = '0;
            res.active  = 1'b1;
         end else begin
            running_in = 1'b0;
         end
      end else if (!running_ff) begin
         // Ticks outside a session leave everything as it is.
      end else if (!armed_ff) begin
         armed_in      = 1'b1;
         start_sec_in  = item.sec;
         start_mod_in  = item.secmod;
         base_steps_in = item.steps & wmt_pkg::CNT_MASK;
         base_dist_in  = item.distance & wmt_pkg::CNT_MASK;
         min_steps_in  = item.steps & wmt_pkg::CNT_MASK;
         min_dist_in   = item.distance & wmt_pkg::CNT_MASK;
         last_mark_in  = '0;
         hold_in       = '0;
         km_done_in    = '0;
         km_next_in    = wmt_pkg::CM_PER_KM;
         res.speed_dd  = speed_dd_ff;
         res.cadence   = cadence_ff;
         res.pace      = pace_ff;
         res.active    = 1'b1;
      end else if (midnight) begin
         running_in = 1'b0;
         armed_in   = 1'b0;
      end else begin
         if (minute_hit) begin
            cadence_in = (min_delta > {16'd0, wmt_pkg::CAD_MAX}) ?
                         wmt_pkg::CAD_MAX : min_delta[15:0];
            if (min_delta >= {24'd0, cfg.min_cadence}) begin
               speed_dd_in = (min_dd >= {14'd0, wmt_pkg::SPD_DD_CLAMP}) ?
                             wmt_pkg::SPD_DD_CLAMP : min_dd[17:0];
            end else begin
               speed_dd_in = '0;
            end
            min_steps_in     = item.steps & wmt_pkg::CNT_MASK;
            min_dist_in      = item.distance & wmt_pkg::CNT_MASK;
            res.full_refresh = 1'b1;
         end

         if (hold_ff > 8'd1) begin
            hold_in = hold_ff - 8'd1;
         end else if (hold_ff == 8'd1) begin
            hold_in          = '0;
            res.full_refresh = 1'b1;
         end

         // At most one kilometre per tick, and only once the hold has run out.
         if (km_reached && (hold_in == 8'd0)) begin
            pace_in = pace_calc;
            hold_in = cfg.pace_hold;
            if (km_done_ff < wmt_pkg::KM_MAX) begin
               km_done_in = km_done_ff + 16'd1;
               km_next_in = km_next_ff + wmt_pkg::CM_PER_KM;
            end
            last_mark_in     = elapsed;
            res.full_refresh = 1'b1;
            res.vibrate      = 1'b1;
         end

         res.elapsed      = elapsed;
         res.steps        = sess_steps;
         res.dist_cm      = sess_cm;
         res.speed_dd     = speed_dd_in;
         res.cadence      = cadence_in;
         res.pace         = pace_in;
         res.pace_visible = (hold_in != 8'd0) &&
                            (pace_in > {5'd0, cfg.show_min}) &&
                            (pace_in < {5'd0, cfg.show_max});
         res.active       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         armed_ff      <= 1'b0;
         start_sec_ff  <= '0;
         start_mod_ff  <= '0;
         base_steps_ff <= '0;
         base_dist_ff  <= '0;
         min_steps_ff  <= '0;
         min_dist_ff   <= '0;
         last_mark_ff  <= '0;
         km_done_ff    <= '0;
         km_next_ff    <= wmt_pkg::CM_PER_KM;
         hold_ff       <= '0;
         speed_dd_ff   <= '0;
         cadence_ff    <= '0;
         pace_ff       <= '0;
      end else if (fire) begin
         running_ff    <= running_in;
         armed_ff      <= armed_in;
         start_sec_ff  <= start_sec_in;
         start_mod_ff  <= start_mod_in;
         base_steps_ff <= base_steps_in;
         base_dist_ff  <= base_dist_in;
         min_steps_ff  <= min_steps_in;
         min_dist_ff   <= min_dist_in;
         last_mark_ff  <= last_mark_in;
         km_done_ff    <= km_done_in;
         km_next_ff    <= km_next_in;
         hold_ff       <= hold_in;
         speed_dd_ff   <= speed_dd_in;
         cadence_ff    <= cadence_in;
         pace_ff       <= pace_in;
      end
   end

endmodule
`default_nettype wire

>>> src/workout_metrics_tracker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Workout metrics tracker core
// Turns one-second ticks and start/stop toggles into session metrics:
// elapsed time, steps, metres, per-minute speed and cadence, intensity stage
// and per-kilometre pace with display flags.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per handshake: a tick (tuser 0) with the clock,
//   wall time and raw counters, or a start/stop toggle (tuser 1).
//   rsp_* returns exactly one result item per input item, in order.
//   csr_* writes the four registers; csr_ready is always high. Write them
//   only while no item is in flight.
// Throughput:
//   The pipeline takes one item per cycle unless the output stalls; the
//   session state is updated in the fifth stage, so each item sees the
//   state left by the one before it. Division by constants is done with
//   registered reciprocal multiplies.
// Reset:
//   Synchronous, active high. Clears the session, the pipeline and restores
//   the register defaults.
// Stalls:
//   While rsp_tready is low, stages behind the output register keep filling
//   bubbles; req_tready drops only when all seven stages hold an item.
// ----------------------------------------------------------------------------
module workout_metrics_tracker_core (
   input  wire logic         clock,
   input  wire logic         reset,
   // Input items.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // clock_ms[31:0], hour_now[36:32], minute_now[42:37], step_counter[74:43],
   // distance_counter[106:75], zero fill [111:107]
   input  wire logic [111:0] req_tdata,
   // opcode[0]
   input  wire logic         req_tuser,
   // Result items.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // elapsed_seconds[16:0], session_steps[48:17], session_metres[74:49],
   // speed_tenths_kmh[84:75], cadence[100:85], intensity_stage[103:101],
   // pace_seconds[120:104], pace_visible[121], full_refresh[122],
   // vibrate[123], session_active[124], zero fill [127:125]
   output logic [127:0]      rsp_tdata,
   // Register writes.
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_addr,
   input  wire logic [11:0]  csr_data
);

   typedef struct packed {
      logic        opcode;
      logic [31:0] clk;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [31:0] steps;
      logic [31:0] distance;
   } raw_type;

   typedef struct packed {
      logic [16:0] elapsed;
      logic [31:0] steps;
      logic [25:0] metres;
      logic [10:0] speed;
      logic [15:0] cadence;
      logic [16:0] pace;
      logic        pace_visible;
      logic        full_refresh;
      logic        vibrate;
      logic        active;
   } post_type;

   // Configuration registers.
   wmt_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_cadence <= wmt_pkg::RST_MIN_CADENCE;
         cfg_ff.pace_hold   <= wmt_pkg::RST_PACE_HOLD;
         cfg_ff.show_min    <= wmt_pkg::RST_SHOW_MIN;
         cfg_ff.show_max    <= wmt_pkg::RST_SHOW_MAX;
      end else if (csr_valid) begin
         unique case (csr_addr)
            wmt_pkg::REG_MIN_CADENCE: cfg_ff.min_cadence <= csr_data[7:0];
            wmt_pkg::REG_PACE_HOLD:   cfg_ff.pace_hold   <= csr_data[7:0];
            wmt_pkg::REG_SHOW_MIN:    cfg_ff.show_min    <= csr_data;
            wmt_pkg::REG_SHOW_MAX:    cfg_ff.show_max    <= csr_data;
            default: ;
         endcase
      end
   end

   // Pipeline flow control: a stage loads when it is empty or its item moves on.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic en1, en2, en3, en4, en5, en6, en7;

   assign en7 = !v7_ff || rsp_tready;
   assign en6 = !v6_ff || en7;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_tready = en1;
   assign rsp_tvalid = v7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
         if (en7) v7_ff <= v6_ff;
      end
   end

   // Stage 1: input register.
   raw_type s1_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff.opcode   <= req_tuser;
         s1_ff.clk      <= req_tdata[31:0];
         s1_ff.hour     <= req_tdata[36:32];
         s1_ff.minute   <= req_tdata[42:37];
         s1_ff.steps    <= req_tdata[74:43];
         s1_ff.distance <= req_tdata[106:75];
      end
   end

   // Stage 2: seconds = clock_ms / 1000.
   logic [58:0]        sec_prod;
   wmt_pkg::item_type  s2_ff;

   assign sec_prod = 59'(s1_ff.clk[31:3]) * 59'(wmt_pkg::DIV125_M36);

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_ff.opcode   <= s1_ff.opcode;
         s2_ff.sec      <= sec_prod[58:36];
         s2_ff.secmod   <= '0;
         s2_ff.hour     <= s1_ff.hour;
         s2_ff.minute   <= s1_ff.minute;
         s2_ff.steps    <= s1_ff.steps;
         s2_ff.distance <= s1_ff.distance;
      end
   end

   // Stage 3: minutes = seconds / 60.
   logic [45:0]        min_prod;
   wmt_pkg::item_type  s3_ff;
   logic [16:0]        q60_ff;

   assign min_prod = 46'(s2_ff.sec[22:2]) * 46'(wmt_pkg::DIV15_M25);

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_ff  <= s2_ff;
         q60_ff <= min_prod[41:25];
      end
   end

   // Stage 4: seconds modulo 60, from q * 60 = q * 64 - q * 4.
   logic [wmt_pkg::SEC_W-1:0] sec_rem;
   wmt_pkg::item_type         s4_ff;

   assign sec_rem = s3_ff.sec - ({q60_ff, 6'd0} - {q60_ff, 2'd0}) ;

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_ff.opcode   <= s3_ff.opcode;
         s4_ff.sec      <= s3_ff.sec;
         s4_ff.secmod   <= sec_rem[5:0];
         s4_ff.hour     <= s3_ff.hour;
         s4_ff.minute   <= s3_ff.minute;
         s4_ff.steps    <= s3_ff.steps;
         s4_ff.distance <= s3_ff.distance;
      end
   end

   // Stage 5: session state update.
   wmt_pkg::sess_res_type ses_res;
   wmt_pkg::sess_res_type s5_ff;
   logic                  ses_fire;

   assign ses_fire = en5 && v4_ff;

   wmt_session u_session (
      .clock (clock),
      .reset (reset),
      .fire  (ses_fire),
      .item  (s4_ff),
      .cfg   (cfg_ff),
      .res   (ses_res)
   );

   always_ff @(posedge clock) begin
      if (en5) s5_ff <= ses_res;
   end

   // Stage 6: metres = cm / 100 and speed = 3 * dd / 500.
   logic [60:0] me_prod;
   logic [19:0] dd_x3;
   logic [35:0] spd_prod;
   post_type    s6_ff;

   assign me_prod  = 61'(s5_ff.dist_cm[31:2]) * 61'(wmt_pkg::DIV25_M35);
   assign dd_x3    = {1'b0, s5_ff.speed_dd, 1'b0} + {2'd0, s5_ff.speed_dd};
   assign spd_prod = 36'(dd_x3[19:2]) * 36'(wmt_pkg::DIV125_M24);

   always_ff @(posedge clock) begin
      if (en6) begin
         s6_ff.elapsed      <= s5_ff.elapsed;
         s6_ff.steps        <= s5_ff.steps;
         s6_ff.metres       <= me_prod[60:35];
         s6_ff.speed        <= spd_prod[34:24];
         s6_ff.cadence      <= s5_ff.cadence;
         s6_ff.pace         <= s5_ff.pace;
         s6_ff.pace_visible <= s5_ff.pace_visible;
         s6_ff.full_refresh <= s5_ff.full_refresh;
         s6_ff.vibrate      <= s5_ff.vibrate;
         s6_ff.active       <= s5_ff.active;
      end
   end

   // Stage 7: speed saturation, intensity stage, output register.
   logic [9:0]   speed_sat;
   logic [2:0]   stage;
   logic [127:0] rsp_data_ff;

   assign speed_sat = (s6_ff.speed > {1'b0, wmt_pkg::SPEED_MAX}) ?
                      wmt_pkg::SPEED_MAX : s6_ff.speed[9:0];

   always_comb begin
      priority if (s6_ff.cadence >= wmt_pkg::STAGE5_MIN) stage = 3'd5;
      else if (s6_ff.cadence >= wmt_pkg::STAGE4_MIN)     stage = 3'd4;
      else if (s6_ff.cadence >= wmt_pkg::STAGE3_MIN)     stage = 3'd3;
      else if (s6_ff.cadence >= wmt_pkg::STAGE2_MIN)     stage = 3'd2;
      else if (s6_ff.cadence >= wmt_pkg::STAGE1_MIN)     stage = 3'd1;
      else                                               stage = 3'd0;
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         rsp_data_ff <= {3'd0, s6_ff.active, s6_ff.vibrate, s6_ff.full_refresh,
                         s6_ff.pace_visible, s6_ff.pace, stage, s6_ff.cadence,
                         speed_sat, s6_ff.metres, s6_ff.steps, s6_ff.elapsed};
      end
   end

   assign rsp_tdata = rsp_data_ff;

`ifndef SYNTHESIS
   a_reset_empties_output: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !en5) |=> (v4_ff && $stable(s4_ff)))
      else $error("stalled item before the session stage was lost or changed");

   a_vibrate_refreshes: assert property (@(posedge clock) disable iff (reset)
      (ses_fire && ses_res.vibrate) |=>
         (v5_ff && s5_ff.vibrate && s5_ff.full_refresh && s5_ff.active))
      else $error("kilometre completion without refresh or active session");
`endif

endmodule
`default_nettype wire
